@@ rtl/binary_min_heap_priority_queue_core_assert.svh @@
// Assertion macros shared by the heap queue RTL.
// Depends on nothing; included by the top level only.
`ifndef BINARY_MIN_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define BINARY_MIN_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define BMHPQ_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define BMHPQ_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/bmhpq_pkg.sv @@
// Types, constants and sequencer states for the binary min-heap queue.
// No dependencies; imported by the top level.
package bmhpq_pkg;

    localparam int unsigned CAPACITY_DEF = 256;
    localparam int unsigned KEY_W        = 16;
    localparam int unsigned PAY_W        = 16;
    localparam int unsigned COUNT_W      = 9;
    localparam int unsigned IN_DATA_W    = 32;
    localparam int unsigned OUT_DATA_W   = 48;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_UP_CMP,
        S_DN_LAST,
        S_DN_CHK,
        S_DN_RDR,
        S_DN_CMP,
        S_FIN
    } state_t;

endpackage

@@ rtl/binary_min_heap_priority_queue_core.sv @@
// Binary min-heap priority queue: one insert or remove per input beat, one result beat each.
// An insert sifts up and a remove sifts down one tree level per step; a reject or a remove
// of the only entry goes straight to the result. The next beat is taken only in idle, in the
// cycle after the result register loads.
// aresetn (synchronous) empties the queue; the RAM needs no clearing pass.
`include "binary_min_heap_priority_queue_core_assert.svh"

module binary_min_heap_priority_queue_core #(
    parameter int unsigned CAPACITY = bmhpq_pkg::CAPACITY_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bmhpq_pkg::IN_DATA_W-1:0]   s_tdata,  // [15:0] key, [31:16] payload
    input  logic [0:0]                        s_tuser,  // [0] op
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] root_key, [31:16] root_payload, [40:32] count, [42:41] status, rest zero
    output logic [bmhpq_pkg::OUT_DATA_W-1:0]  m_tdata
);

    import bmhpq_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    pos_reg, pos_next;
    entry_t           cur_reg, cur_next;
    entry_t           left_reg, left_next;
    entry_t           root_reg, root_next;
    entry_t           root_out;
    status_t          status_reg, status_next;
    logic             m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    entry_t           ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata_raw;
    entry_t           ram_rdata;

    logic [AW+1:0]    left_idx, right_idx, cnt_ext;
    logic             has_left, has_right;
    logic [AW-1:0]    parent_idx;
    logic             pick_right, do_swap, climb, accept, out_free, is_full;
    entry_t           pick;
    logic [AW-1:0]    pick_idx;
    logic             fin_load, count_ok, wr_live;

    bmhpq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata_raw)
    );

    assign ram_rdata = entry_t'(ram_rdata_raw);

    // Tree arithmetic around the current hole position.
    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + (AW+2)'(1);
    assign cnt_ext    = (AW+2)'(count_reg);
    assign has_left   = left_idx < cnt_ext;
    assign has_right  = right_idx < cnt_ext;
    assign parent_idx = (pos_reg - AW'(1)) >> 1;

    assign pick_right = has_right && (ram_rdata.key < left_reg.key);
    assign pick       = pick_right ? ram_rdata : left_reg;
    assign pick_idx   = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
    assign do_swap    = cur_reg.key > pick.key;
    assign climb      = cur_reg.key < ram_rdata.key;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign is_full  = count_reg == CW'(CAPACITY);
    assign fin_load = (state_reg == S_FIN) && out_free;
    assign root_out = (count_reg != '0) ? root_reg : '0;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_tuser[0] == OP_INSERT) begin
                        state_next = is_full ? S_FIN : S_UP;
                    end else if (count_reg > CW'(1)) begin
                        state_next = S_DN_LAST;
                    end else begin
                        state_next = S_FIN;
                    end
                end
            end
            S_UP:      state_next = (pos_reg == '0) ? S_FIN : S_UP_CMP;
            S_UP_CMP:  state_next = climb ? S_UP : S_FIN;
            S_DN_LAST: state_next = S_DN_CHK;
            S_DN_CHK:  state_next = has_left ? S_DN_RDR : S_FIN;
            S_DN_RDR:  state_next = S_DN_CMP;
            S_DN_CMP:  state_next = do_swap ? S_DN_CHK : S_FIN;
            S_FIN:     state_next = out_free ? S_IDLE : S_FIN;
            default:   state_next = S_IDLE;
        endcase
    end

    // Datapath and RAM control. The entry in flight rides in cur_reg and is
    // written once, where the sift stops; reads and writes never share a cycle
    // on the same slot, so no forwarding is needed.
    always_comb begin
        s_tready    = state_reg == S_IDLE;
        count_next  = count_reg;
        pos_next    = pos_reg;
        cur_next    = cur_reg;
        left_next   = left_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = pos_reg;
        ram_wdata   = cur_reg;
        ram_raddr   = parent_idx;
        case (state_reg)
            S_IDLE: begin
                ram_raddr = AW'(count_reg - CW'(1));
                if (accept) begin
                    status_next = ST_OK;
                    if (s_tuser[0] == OP_INSERT) begin
                        if (is_full) begin
                            status_next = ST_FULL;
                        end else begin
                            cur_next   = '{key: s_tdata[KEY_W-1:0],
                                           payload: s_tdata[KEY_W+PAY_W-1:KEY_W]};
                            pos_next   = AW'(count_reg);
                            count_next = count_reg + CW'(1);
                        end
                    end else if (count_reg == '0) begin
                        status_next = ST_EMPTY;
                    end else begin
                        count_next = count_reg - CW'(1);
                        pos_next   = '0;
                    end
                end
            end
            S_UP: begin
                ram_raddr = parent_idx;
                if (pos_reg == '0) begin
                    ram_we = 1'b1;
                end
            end
            S_UP_CMP: begin
                ram_we = 1'b1;
                if (climb) begin
                    ram_wdata = ram_rdata;
                    pos_next  = parent_idx;
                end
            end
            S_DN_LAST: begin
                cur_next = ram_rdata;
            end
            S_DN_CHK: begin
                ram_raddr = left_idx[AW-1:0];
                if (!has_left) begin
                    ram_we = 1'b1;
                end
            end
            S_DN_RDR: begin
                left_next = ram_rdata;
                ram_raddr = right_idx[AW-1:0];
            end
            S_DN_CMP: begin
                ram_we = 1'b1;
                if (do_swap) begin
                    ram_wdata = pick;
                    pos_next  = pick_idx;
                end
            end
            default: begin
            end
        endcase
        root_next = (ram_we && ram_waddr == '0) ? ram_wdata : root_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (fin_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        cur_reg    <= cur_next;
        left_reg   <= left_next;
        root_reg   <= root_next;
        status_reg <= status_next;
        if (fin_load) begin
            m_tdata_reg <= OUT_DATA_W'({status_reg, COUNT_W'(count_reg),
                                        root_out.payload, root_out.key});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign count_ok = count_reg <= CW'(CAPACITY);
    assign wr_live  = CW'(ram_waddr) < count_reg;

    `BMHPQ_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_ok, "entry count above capacity")
    `BMHPQ_ASSERT_IMPLIES(a_write_in_heap, aclk, aresetn, ram_we, wr_live, "stray store write")
    `BMHPQ_ASSERT_IMPLIES(a_fin_beat, aclk, aresetn, $rose(m_tvalid), $past(fin_load), "stray beat")

endmodule

@@ rtl/bmhpq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used for the heap entry store.
module bmhpq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for binary_min_heap_priority_queue_core: a directed table, then
// fill, drain and mixed random phases checked against an in-bench heap predictor.
// Depends on bmhpq_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;
    import bmhpq_pkg::*;

    localparam int unsigned HEAP_DEPTH  = CAPACITY_DEF;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_WAIT  = 40;

    typedef struct {
        logic [KEY_W-1:0]   root_key;
        logic [PAY_W-1:0]   root_payload;
        logic [COUNT_W-1:0] count;
        status_t            status;
    } heap_result_t;

    typedef struct {
        logic         op;
        logic [15:0]  key;
        logic [15:0]  payload;
        bit           typed;
        heap_result_t want;
    } stim_row_t;

    localparam heap_result_t NO_WANT = '{16'h0000, 16'h0000, 9'd0, ST_OK};
    localparam int unsigned DIR_ROWS = 21;

    // Rows with typed = 1 carry a result that can be read off directly; the rest use
    // the predictor. Equal keys are paired with different payloads to expose tie order.
    stim_row_t dir_table [DIR_ROWS] = '{
        '{OP_REMOVE, 16'h0000, 16'h0000, 1'b1, '{16'h0000, 16'h0000, 9'd0, ST_EMPTY}},
        '{OP_REMOVE, 16'hFFFF, 16'hFFFF, 1'b1, '{16'h0000, 16'h0000, 9'd0, ST_EMPTY}},
        '{OP_INSERT, 16'hFFFF, 16'hFFFF, 1'b1, '{16'hFFFF, 16'hFFFF, 9'd1, ST_OK}},
        '{OP_REMOVE, 16'h1234, 16'h4321, 1'b1, '{16'h0000, 16'h0000, 9'd0, ST_OK}},
        '{OP_INSERT, 16'h8000, 16'h1234, 1'b1, '{16'h8000, 16'h1234, 9'd1, ST_OK}},
        '{OP_INSERT, 16'h8000, 16'h5678, 1'b1, '{16'h8000, 16'h1234, 9'd2, ST_OK}},
        '{OP_INSERT, 16'h7FFF, 16'h0001, 1'b1, '{16'h7FFF, 16'h0001, 9'd3, ST_OK}},
        '{OP_INSERT, 16'h0000, 16'hFFFF, 1'b1, '{16'h0000, 16'hFFFF, 9'd4, ST_OK}},
        '{OP_INSERT, 16'h0000, 16'h0000, 1'b0, NO_WANT},
        '{OP_INSERT, 16'hFFFF, 16'h0000, 1'b0, NO_WANT},
        '{OP_INSERT, 16'h0001, 16'hAAAA, 1'b0, NO_WANT},
        '{OP_INSERT, 16'h0001, 16'h5555, 1'b0, NO_WANT},
        '{OP_REMOVE, 16'h0000, 16'h0000, 1'b0, NO_WANT},
        '{OP_REMOVE, 16'h0000, 16'hFFFF, 1'b0, NO_WANT},
        '{OP_REMOVE, 16'hFFFF, 16'h0000, 1'b0, NO_WANT},
        '{OP_REMOVE, 16'hAAAA, 16'h5555, 1'b0, NO_WANT},
        '{OP_REMOVE, 16'h5555, 16'hAAAA, 1'b0, NO_WANT},
        '{OP_REMOVE, 16'h0000, 16'h0000, 1'b0, NO_WANT},
        '{OP_REMOVE, 16'h0000, 16'h0000, 1'b0, NO_WANT},
        '{OP_REMOVE, 16'h0000, 16'h0000, 1'b1, '{16'h0000, 16'h0000, 9'd0, ST_OK}},
        '{OP_REMOVE, 16'hFFFF, 16'hFFFF, 1'b1, '{16'h0000, 16'h0000, 9'd0, ST_EMPTY}}
    };

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // [15:0] key, [31:16] payload
    logic [0:0]            s_tuser  = '0;   // [0] op
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // [15:0] root_key, [31:16] root_payload,
                                            // [40:32] count, [42:41] status

    binary_min_heap_priority_queue_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Predictor state: a shadow copy of the heap array and its fill level.
    entry_t       heap_img [HEAP_DEPTH];
    int unsigned  heap_cnt;
    heap_result_t pending_results [$];

    int unsigned  mismatches;
    int unsigned  cycle_cnt;
    int unsigned  beats_sent;
    int unsigned  inserts_ok;
    int unsigned  removes_ok;
    int unsigned  full_rejects;
    int unsigned  empty_removes;
    int unsigned  heap_peak;
    int unsigned  burst_left;

    function automatic heap_result_t apply_heap_op(input logic op, input logic [15:0] key,
                                                   input logic [15:0] payload);
        heap_result_t res;
        entry_t       tmp;
        int unsigned  pos;
        int unsigned  up;
        int unsigned  left;
        int unsigned  pick;
        res.status = ST_OK;
        if (op == OP_INSERT) begin
            if (heap_cnt >= HEAP_DEPTH) begin
                res.status = ST_FULL;
                full_rejects++;
            end else begin
                pos = heap_cnt;
                heap_img[pos].key     = key;
                heap_img[pos].payload = payload;
                while (pos > 0) begin
                    up = (pos - 1) / 2;
                    if (heap_img[pos].key >= heap_img[up].key) break;
                    tmp = heap_img[pos];
                    heap_img[pos] = heap_img[up];
                    heap_img[up] = tmp;
                    pos = up;
                end
                heap_cnt++;
                inserts_ok++;
                if (heap_cnt > heap_peak) heap_peak = heap_cnt;
            end
        end else begin
            if (heap_cnt == 0) begin
                res.status = ST_EMPTY;
                empty_removes++;
            end else begin
                heap_cnt--;
                heap_img[0] = heap_img[heap_cnt];
                pos = 0;
                while (1) begin
                    left = 2 * pos + 1;
                    if (left >= heap_cnt) break;
                    pick = left;
                    // Right child wins only when strictly smaller than the left one.
                    if (left + 1 < heap_cnt && heap_img[left + 1].key < heap_img[left].key)
                        pick = left + 1;
                    if (heap_img[pos].key <= heap_img[pick].key) break;
                    tmp = heap_img[pos];
                    heap_img[pos] = heap_img[pick];
                    heap_img[pick] = tmp;
                    pos = pick;
                end
                removes_ok++;
            end
        end
        res.root_key     = (heap_cnt > 0) ? heap_img[0].key : 16'h0000;
        res.root_payload = (heap_cnt > 0) ? heap_img[0].payload : 16'h0000;
        res.count        = heap_cnt[COUNT_W-1:0];
        return res;
    endfunction

    // Keys lean toward a narrow range so that ties at both sift directions are common.
    function automatic logic [15:0] pick_key();
        logic [15:0] k;
        case ($urandom_range(0, 7))
            0:       k = 16'h0000;
            1:       k = 16'hFFFF;
            2, 3:    k = 16'($urandom_range(0, 7));
            4:       k = {1'b1, 15'($urandom_range(0, 3))};
            default: k = 16'($urandom);
        endcase
        return k;
    endfunction

    // Drives one beat, waits for the handshake, then records the expected result.
    // Bursts of back-to-back beats alternate with random idle gaps.
    task automatic push_beat(input logic op, input logic [15:0] key, input logic [15:0] payload,
                             input bit typed, input heap_result_t typed_want);
        heap_result_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {payload, key};
        do @(posedge aclk); while (s_tready !== 1'b1);
        predicted = apply_heap_op(op, key, payload);
        pending_results.push_back(typed ? typed_want : predicted);
        beats_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    task automatic random_beat(input int unsigned insert_pct);
        logic op;
        op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        push_beat(op, pick_key(), 16'($urandom), 1'b0, NO_WANT);
    endtask

    task automatic fill_heap();
        while (heap_cnt < HEAP_DEPTH) random_beat(92);
        repeat (4) random_beat(100);
    endtask

    task automatic drain_heap();
        while (heap_cnt > 0) random_beat(8);
        repeat (3) random_beat(0);
    endtask

    // The receiver switches between always ready, random, sparse and periodic stalls.
    int unsigned stall_mode;
    int unsigned stall_left;

    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 0);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (cycle_cnt[2:0] != 3'b000);
        endcase
    end

    heap_result_t want;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: m_tdata=%h", m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[15:0] !== want.root_key) begin
                    $error("root_key: expected %h, got %h", want.root_key, m_tdata[15:0]);
                    mismatches++;
                end
                if (m_tdata[31:16] !== want.root_payload) begin
                    $error("root_payload: expected %h, got %h",
                           want.root_payload, m_tdata[31:16]);
                    mismatches++;
                end
                if (m_tdata[40:32] !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, m_tdata[40:32]);
                    mismatches++;
                end
                if (m_tdata[42:41] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[42:41]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_cnt, pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        heap_cnt      = 0;
        mismatches    = 0;
        cycle_cnt     = 0;
        beats_sent    = 0;
        inserts_ok    = 0;
        removes_ok    = 0;
        full_rejects  = 0;
        empty_removes = 0;
        heap_peak     = 0;
        burst_left    = 0;
        stall_mode    = 0;
        stall_left    = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++)
            push_beat(dir_table[i].op, dir_table[i].key, dir_table[i].payload,
                      dir_table[i].typed, dir_table[i].want);

        fill_heap();
        drain_heap();
        repeat (100) random_beat(60);
        fill_heap();
        drain_heap();

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Sent %0d beats: %0d inserts, %0d removes, %0d full rejects, %0d empty removes.",
                 beats_sent, inserts_ok, removes_ok, full_rejects, empty_removes);
        $display("Heap peaked at %0d entries; %0d mismatches seen.", heap_peak, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/bmhpq_pkg.sv
rtl/bmhpq_ram.sv
rtl/binary_min_heap_priority_queue_core.sv
dv/testbench.sv
